@@ design/fpa_pkg.sv @@
// Package with operation codes and the shared control type of the fixed-point ALU.
`default_nettype none
package fpa_pkg;

   // Operation codes carried by a request.
   localparam logic [3:0] OP_ADD     = 4'd0;
   localparam logic [3:0] OP_SUB     = 4'd1;
   localparam logic [3:0] OP_MUL     = 4'd2;
   localparam logic [3:0] OP_DIV     = 4'd3;
   localparam logic [3:0] OP_GT      = 4'd4;
   localparam logic [3:0] OP_LT      = 4'd5;
   localparam logic [3:0] OP_GE      = 4'd6;
   localparam logic [3:0] OP_LE      = 4'd7;
   localparam logic [3:0] OP_EQ      = 4'd8;
   localparam logic [3:0] OP_NE      = 4'd9;
   localparam logic [3:0] OP_MIN     = 4'd10;
   localparam logic [3:0] OP_MAX     = 4'd11;
   localparam logic [3:0] OP_FROMINT = 4'd12;
   localparam logic [3:0] OP_TOINT   = 4'd13;
   localparam logic [3:0] OP_INC     = 4'd14;
   localparam logic [3:0] OP_DEC     = 4'd15;

   // Width of the fields on the external channels.
   localparam int unsigned PORT_WIDTH = 32;

   // Classification of a request made by the front end.
   typedef struct packed {
      logic [3:0] op;
      logic       is_div;
      logic       is_mul;
   } ctrl_type;

endpackage
`default_nettype wire

@@ design/fpa_req_if.sv @@
// Request channel interface of the fixed-point ALU.
`default_nettype none
interface fpa_req_if;
   logic              valid;
   logic              ready;
   logic [3:0]        operation;
   logic signed [31:0] operand_a;
   logic signed [31:0] operand_b;

   modport source (output valid, output operation, output operand_a, output operand_b,
                   input ready);
   modport sink (input valid, input operation, input operand_a, input operand_b,
                 output ready);
endinterface
`default_nettype wire

@@ design/fpa_rsp_if.sv @@
// Result channel interface of the fixed-point ALU.
`default_nettype none
interface fpa_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_word;
   logic               compare_true;
   logic               divide_by_zero;

   modport source (output valid, output result_word, output compare_true,
                   output divide_by_zero, input ready);
   modport sink (input valid, input result_word, input compare_true,
                 input divide_by_zero, output ready);
endinterface
`default_nettype wire

@@ design/fixed_point_alu_top.sv @@
// A request passes through the queue, the entry stage and the divider stages to the result.
// Throughput: one request per cycle while results are taken, as the divider is pipelined.
// The whole back-end pipeline holds while a finished result waits to be taken.
// Reset (synchronous) empties the queue and clears every pipeline valid bit.
// Top level of the fixed-point ALU.
`default_nettype none
module fixed_point_alu_top import fpa_pkg::*; #(
   parameter int unsigned FRACTION_BITS = 8,
   parameter int unsigned WORD_WIDTH    = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   fpa_req_if.sink   req_bus,
   fpa_rsp_if.source rsp_bus
);

   localparam int unsigned QW = $bits(ctrl_type) + 2 * WORD_WIDTH;

   logic                  queue_ready, push_valid, head_valid, pop;
   ctrl_type              push_ctrl, head_ctrl;
   logic [WORD_WIDTH-1:0] push_a, push_b, head_a, head_b;
   logic [QW-1:0]         head_data;

   fpa_front #(.WORD_WIDTH(WORD_WIDTH)) u_front (
      .req_bus     (req_bus),
      .queue_ready (queue_ready),
      .push_valid  (push_valid),
      .push_ctrl   (push_ctrl),
      .push_a      (push_a),
      .push_b      (push_b)
   );

   fpa_queue #(.DATA_WIDTH(QW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  ({push_ctrl, push_a, push_b}),
      .push_ready (queue_ready),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   assign {head_ctrl, head_a, head_b} = head_data;

   fpa_back #(.WORD_WIDTH(WORD_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_ctrl  (head_ctrl),
      .head_a     (head_a),
      .head_b     (head_b),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

   // A comparison result never carries a word or a divide error.
   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.compare_true |->
         rsp_bus.result_word == '0 && !rsp_bus.divide_by_zero)
      else $error("comparison result carries data");

   // A zero divisor gives a zero word.
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.divide_by_zero |-> rsp_bus.result_word == '0)
      else $error("divide by zero gave a nonzero word");

   // The queue only pops while the back end can move.
   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid && (!rsp_bus.valid || rsp_bus.ready))
      else $error("queue popped during a stall");

endmodule
`default_nettype wire

@@ design/fpa_front.sv @@
// Front end: takes requests, narrows the operands and classifies the operation.
`default_nettype none
module fpa_front import fpa_pkg::*; #(
   parameter int unsigned WORD_WIDTH = 32
) (
   fpa_req_if.sink               req_bus,
   input  wire logic             queue_ready,
   output logic                  push_valid,
   output ctrl_type              push_ctrl,
   output logic [WORD_WIDTH-1:0] push_a,
   output logic [WORD_WIDTH-1:0] push_b
);

   // A request enters whenever the queue has room.
   assign req_bus.ready = queue_ready;
   assign push_valid    = req_bus.valid;

   // Operands keep their low word bits; the back end treats them as signed.
   assign push_a = req_bus.operand_a[WORD_WIDTH-1:0];
   assign push_b = req_bus.operand_b[WORD_WIDTH-1:0];

   // Classify the operation for the back end.
   always_comb begin
      push_ctrl.op     = req_bus.operation;
      push_ctrl.is_div = (req_bus.operation == OP_DIV);
      push_ctrl.is_mul = (req_bus.operation == OP_MUL);
   end

endmodule
`default_nettype wire

@@ design/fpa_queue.sv @@
// Two-entry queue that decouples the front end from the back end.
`default_nettype none
module fpa_queue #(
   parameter int unsigned DATA_WIDTH = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   input  wire logic [DATA_WIDTH-1:0] push_data,
   output logic                       push_ready,
   output logic                       head_valid,
   output logic [DATA_WIDTH-1:0]      head_data,
   input  wire logic                  pop
);

   logic [DATA_WIDTH-1:0] entry_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ design/fpa_back.sv @@
// Back end: executes operations in a pipeline with a one-bit-per-stage divider.
`default_nettype none
module fpa_back import fpa_pkg::*; #(
   parameter int unsigned WORD_WIDTH    = 32,
   parameter int unsigned FRACTION_BITS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  head_valid,
   input  wire ctrl_type              head_ctrl,
   input  wire logic [WORD_WIDTH-1:0] head_a,
   input  wire logic [WORD_WIDTH-1:0] head_b,
   output logic                       pop,
   fpa_rsp_if.source                  rsp_bus
);

   localparam int unsigned W  = WORD_WIDTH;
   localparam int unsigned F  = FRACTION_BITS;
   localparam int unsigned DW = W + F;
   localparam int unsigned NS = DW + 1;

   typedef struct packed {
      logic          valid;
      logic          is_div;
      logic          is_mul;
      logic          cmp;
      logic          dz;
      logic          neg;
      logic [W-1:0]  result;
      logic [W-1:0]  rem;
      logic [DW-1:0] quo;
      logic [W-1:0]  divisor;
   } stage_type;

   stage_type           st_ff [NS];
   stage_type           first_in;
   logic signed [2*W-1:0] prod_ff, prod_in;
   logic signed [W-1:0] a, b;
   logic [W-1:0]        a_mag, b_mag;
   logic                advance;

   assign a       = $signed(head_a);
   assign b       = $signed(head_b);
   assign advance = !st_ff[NS-1].valid || rsp_bus.ready;
   assign pop     = advance && head_valid;
   assign a_mag   = a[W-1] ? W'(-a) : W'(a);
   assign b_mag   = b[W-1] ? W'(-b) : W'(b);
   assign prod_in = a * b;

   // Simple operations, comparisons and divider setup for the entering request.
   always_comb begin
      first_in         = '0;
      first_in.valid   = head_valid;
      first_in.is_div  = head_ctrl.is_div;
      first_in.is_mul  = head_ctrl.is_mul;
      first_in.dz      = head_ctrl.is_div && (b == '0);
      first_in.neg     = a[W-1] ^ b[W-1];
      first_in.quo     = DW'(a_mag) << F;
      first_in.divisor = b_mag;
      case (head_ctrl.op)
         OP_ADD:     first_in.result = W'(a + b);
         OP_SUB:     first_in.result = W'(a - b);
         OP_GT:      first_in.cmp = (a > b);
         OP_LT:      first_in.cmp = (a < b);
         OP_GE:      first_in.cmp = (a >= b);
         OP_LE:      first_in.cmp = (a <= b);
         OP_EQ:      first_in.cmp = (a == b);
         OP_NE:      first_in.cmp = (a != b);
         OP_MIN:     first_in.result = (a < b) ? a : b;
         OP_MAX:     first_in.result = (a > b) ? a : b;
         OP_FROMINT: first_in.result = W'(a <<< F);
         OP_TOINT:   first_in.result = W'(a >>> F);
         OP_INC:     first_in.result = W'(a + 1);
         OP_DEC:     first_in.result = W'(a - 1);
         default:    first_in.result = '0;
      endcase
   end

   // Entry stage and product register.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff[0].valid <= 1'b0;
      end else if (advance) begin
         st_ff[0] <= first_in;
         prod_ff  <= prod_in;
      end
   end

   // Each later stage resolves one quotient bit; the first also folds in the product.
   for (genvar i = 0; i < NS - 1; i++) begin : g_stage
      logic [W:0]  trial;
      logic [W:0]  diff;
      stage_type   stage_in;

      always_comb begin
         stage_in = st_ff[i];
         trial    = {st_ff[i].rem, st_ff[i].quo[DW-1]};
         diff     = trial - {1'b0, st_ff[i].divisor};
         if (!diff[W]) begin
            stage_in.rem = diff[W-1:0];
            stage_in.quo = {st_ff[i].quo[DW-2:0], 1'b1};
         end else begin
            stage_in.rem = trial[W-1:0];
            stage_in.quo = {st_ff[i].quo[DW-2:0], 1'b0};
         end
         if (i == 0 && st_ff[i].is_mul) begin
            stage_in.result = prod_ff[F+W-1:F];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[i+1].valid <= 1'b0;
         end else if (advance) begin
            st_ff[i+1] <= stage_in;
         end
      end
   end

   // Final sign fix of the quotient and output selection.
   logic [DW-1:0] quo_signed;
   logic signed [W-1:0] final_word;

   always_comb begin
      quo_signed = st_ff[NS-1].neg ? DW'(-st_ff[NS-1].quo) : st_ff[NS-1].quo;
      if (st_ff[NS-1].is_div) begin
         final_word = st_ff[NS-1].dz ? '0 : $signed(quo_signed[W-1:0]);
      end else begin
         final_word = $signed(st_ff[NS-1].result);
      end
   end

   assign rsp_bus.valid          = st_ff[NS-1].valid;
   assign rsp_bus.result_word    = PORT_WIDTH'(final_word);
   assign rsp_bus.compare_true   = st_ff[NS-1].cmp;
   assign rsp_bus.divide_by_zero = st_ff[NS-1].dz;

endmodule
`default_nettype wire

@@ bench/fixed_point_alu_checker.sv @@
// Checker that predicts fixed-point ALU results from accepted requests and compares them.
`default_nettype none
module fixed_point_alu_checker import fpa_pkg::*; #(
   parameter int unsigned FRACTION_BITS = 8,
   parameter int unsigned WORD_WIDTH    = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   fpa_req_if        req_mon,
   fpa_rsp_if        rsp_mon,
   output int        failures,
   output int        pending
);

   typedef struct {
      logic signed [31:0] word;
      logic               cmp;
      logic               dz;
   } alu_result_type;

   alu_result_type expected_results[$];

   // Take the low WORD_WIDTH bits of a word, sign-extended to 64 bits.
   function automatic longint narrow(input longint x);
      longint m;
      m = x << (64 - WORD_WIDTH);
      return m >>> (64 - WORD_WIDTH);
   endfunction

   // Compute the result of one request.
   function automatic alu_result_type alu_compute(input logic [3:0] op,
                                                  input logic signed [31:0] ra,
                                                  input logic signed [31:0] rb);
      alu_result_type res;
      longint a, b, r;
      a = narrow(longint'(ra));
      b = narrow(longint'(rb));
      r = 0;
      res.cmp = 1'b0;
      res.dz = 1'b0;
      case (op)
         OP_ADD: r = a + b;
         OP_SUB: r = a - b;
         OP_MUL: r = (a * b) >>> FRACTION_BITS;
         OP_DIV: begin
            if (b == 0) res.dz = 1'b1;
            else r = (a * (64'sd1 << FRACTION_BITS)) / b;
         end
         OP_GT: res.cmp = a > b;
         OP_LT: res.cmp = a < b;
         OP_GE: res.cmp = a >= b;
         OP_LE: res.cmp = a <= b;
         OP_EQ: res.cmp = a == b;
         OP_NE: res.cmp = a != b;
         OP_MIN: r = (a < b) ? a : b;
         OP_MAX: r = (a > b) ? a : b;
         OP_FROMINT: r = a * (64'sd1 << FRACTION_BITS);
         OP_TOINT: r = a >>> FRACTION_BITS;
         OP_INC: r = a + 1;
         default: r = a - 1;
      endcase
      r = narrow(r);
      res.word = r[31:0];
      return res;
   endfunction

   assign pending = expected_results.size();

   // Record requests and compare results at every edge.
   always @(posedge clock) begin
      alu_result_type exp_res;
      if (reset) begin
         expected_results.delete();
         failures <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(alu_compute(req_mon.operation, req_mon.operand_a,
                                                   req_mon.operand_b));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               if (failures < 10) $display("Unexpected result word %h", rsp_mon.result_word);
               failures <= failures + 1;
            end else begin
               exp_res = expected_results.pop_front();
               if (rsp_mon.result_word !== exp_res.word || rsp_mon.compare_true !== exp_res.cmp
                   || rsp_mon.divide_by_zero !== exp_res.dz) begin
                  if (failures < 10)
                     $display("Mismatch: expected word %h cmp %b dz %b, got word %h cmp %b dz %b",
                              exp_res.word, exp_res.cmp, exp_res.dz, rsp_mon.result_word,
                              rsp_mon.compare_true, rsp_mon.divide_by_zero);
                  failures <= failures + 1;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

@@ bench/fixed_point_alu_top_test.sv @@
// Testbench top that drives requests into the fixed-point ALU and reports the verdict.
`default_nettype none
module fixed_point_alu_top_test;
   import fpa_pkg::*;

   localparam int LATENCY = 32 + 8 + 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   failures;
   int   pending;
   logic hold_off = 1'b0;
   logic drain_done = 1'b0;

   fpa_req_if req_bus();
   fpa_rsp_if rsp_bus();

   fixed_point_alu_top DUT (.clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus));

   fixed_point_alu_checker checker_inst (.clock(clock), .reset(reset), .req_mon(req_bus),
                                         .rsp_mon(rsp_bus), .failures(failures),
                                         .pending(pending));

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Pick an operand: mostly an edge value, otherwise a small or a full random value.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3: return 32'hffff_ffff;
         4: return 32'h0000_0100;
         5: return 32'hffff_ff00;
         6: return $urandom_range(0, 1023) - 512;
         default: return $urandom;
      endcase
   endfunction

   // Offer one request and wait until it is taken.
   task automatic send_request(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.operand_a <= a;
      req_bus.operand_b <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Result-side stalls, with one long hold-off in the middle of the run.
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // Request stimulus.
   initial begin
      logic [31:0] edges[6];
      int gap;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_ADD;
      req_bus.operand_a = '0;
      req_bus.operand_b = '0;
      edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h100, 32'h1};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // Directed: every operation on extremes, zero divisor, most negative over -1.
      for (int op = 0; op < 16; op++)
         send_request(op[3:0], edges[op % 6], edges[(op + 3) % 6]);
      send_request(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
      send_request(OP_DIV, 32'h1234_5678, 32'h0);
      send_request(OP_MIN, 32'h55, 32'h55);
      send_request(OP_MAX, 32'hffff_ff80, 32'hffff_ff80);
      send_request(OP_TOINT, 32'hffff_ff01, 32'h0);
      send_request(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
      // Random traffic with gaps, a long result hold-off and one full drain.
      for (int i = 0; i < 1800; i++) begin
         if (i == 600) hold_off = 1'b1;
         if (i == 1200) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         gap = (i >= 600 && i < 700) ? 0 :
               (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         send_request(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
      end
      req_bus.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      drain_done = 1'b1;
      if (failures == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog for a hung run.
   initial begin
      #2000000;
      if (!drain_done) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule
`default_nettype wire

@@ fixed_point_alu_top.f @@
design/fpa_pkg.sv
design/fpa_req_if.sv
design/fpa_rsp_if.sv
design/fpa_front.sv
design/fpa_queue.sv
design/fpa_back.sv
design/fixed_point_alu_top.sv
bench/fixed_point_alu_checker.sv
bench/fixed_point_alu_top_test.sv
